// ===== design/energy_beat_tempo_detector_unit_macros.svh =====
`ifndef ENERGY_BEAT_TEMPO_DETECTOR_UNIT_MACROS_SVH
`define ENERGY_BEAT_TEMPO_DETECTOR_UNIT_MACROS_SVH

// Assertion helpers for the beat detector checker. They expect clk_i and
// rst_ni in the scope where they are used.

// Same-cycle implication.
`define EBTD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define EBTD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ebtd_pkg.sv =====
`timescale 1ns / 1ps

package ebtd_pkg;

  // Field widths.
  localparam int ENERGY_W   = 32;
  localparam int TIME_W     = 63;
  localparam int GAP_W      = 32;
  localparam int GAIN_W     = 10;
  localparam int TEMPO_W    = 17;
  localparam int CONF_W     = 12;
  localparam int Q_FRAC     = 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 1'b1;

  // Energy history.
  localparam int ENERGY_DEPTH = 16;
  localparam int ESLOT_W      = $clog2(ENERGY_DEPTH);
  localparam int ESUM_W       = ENERGY_W + ESLOT_W;

  // Beat interval history.
  localparam int INTERVAL_DEPTH = 8;
  localparam int ISLOT_W        = (INTERVAL_DEPTH > 1) ? $clog2(INTERVAL_DEPTH) : 1;
  localparam int IVAL_W         = 32;
  localparam int ISUM_W         = IVAL_W + $clog2(INTERVAL_DEPTH);
  localparam int BEATS_W        = $clog2(INTERVAL_DEPTH + 2);

  // Tempo numerator: 60e6 us per minute times 256 for Q8.
  localparam int TNUM_BASE_W = 34;
  localparam int TNUM_W      = TNUM_BASE_W + BEATS_W;
  localparam logic [TNUM_BASE_W-1:0] TEMPO_NUM = 34'd15360000000;

  // Datapath widths.
  localparam int PROD_W   = GAIN_W + ENERGY_W;
  localparam int SCALED_W = ENERGY_W + Q_FRAC;
  localparam int DREM_W   = ISUM_W;
  localparam int DCNT_W   = $clog2(TEMPO_W + 1);

  // Saturation and reset values.
  localparam logic [TEMPO_W-1:0] TEMPO_MAX     = {TEMPO_W{1'b1}};
  localparam logic [CONF_W-1:0]  CONF_MAX      = {CONF_W{1'b1}};
  localparam logic [TEMPO_W-1:0] TEMPO_RESET   = 17'd30720;
  localparam logic [GAP_W-1:0]   MIN_GAP_RESET = 32'd200000;
  localparam logic [GAIN_W-1:0]  GAIN_RESET    = 10'd333;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_DECIDE,
    ST_TLOAD,
    ST_CHECK,
    ST_ITER,
    ST_CLOAD,
    ST_OUT
  } st_e;

endpackage

// ===== design/ebtd_in_if.sv =====
`timescale 1ns / 1ps

interface ebtd_in_if;
  import ebtd_pkg::*;

  logic                valid;
  logic                ready;
  logic [ENERGY_W-1:0] frame_energy;
  logic [TIME_W-1:0]   time_us;

  modport source (output valid, output frame_energy, output time_us, input ready);
  modport sink   (input valid, input frame_energy, input time_us, output ready);
endinterface

// ===== design/ebtd_out_if.sv =====
`timescale 1ns / 1ps

interface ebtd_out_if;
  import ebtd_pkg::*;

  logic               valid;
  logic               ready;
  logic               beat;
  logic [TEMPO_W-1:0] tempo_q8;
  logic [CONF_W-1:0]  confidence_q8;

  modport source (output valid, output beat, output tempo_q8, output confidence_q8,
                  input ready);
  modport sink   (input valid, input beat, input tempo_q8, input confidence_q8,
                  output ready);
endinterface

// ===== design/energy_beat_tempo_detector_unit.sv =====
// Energy beat and tempo detector. Each input word carries one frame energy
// and its timestamp in microseconds; each one produces exactly one output word
// with the beat flag and the held tempo (Q9.8 BPM) and confidence (Q4.8). A
// frame is a beat when its energy times 256 exceeds the gain register times the
// mean of the last sixteen energies (the current one included) and more than
// min_gap_us has passed since the previous beat. A frame that is not a beat passes
// the test, decide and output states; the first beat adds the confidence
// division, and later beats add the tempo division before it; a saturating
// division finishes early. Both use the one shared restoring divider, which
// produces one quotient bit per cycle, 17 bits for the tempo and 12 bits for the
// confidence, each preceded by a single overflow check. A finished word waits in
// the output register, so the next frame can be accepted before it is taken. No
// clearing pass is needed after reset. Configuration must be written only while
// the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps

module energy_beat_tempo_detector_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ebtd_in_if.sink                         in_i,
  ebtd_out_if.source                      out_o,
  input  logic                            cfg_we_i,
  input  logic [ebtd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ebtd_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ebtd_pkg::*;

  // Sequencer state.
  st_e state_q, state_d;

  // Configuration registers.
  logic [GAP_W-1:0]  min_gap_q;
  logic [GAIN_W-1:0] gain_q;

  // Energy history with its running sum, so the mean never needs a sweep.
  logic [ENERGY_W-1:0] ering_q [ENERGY_DEPTH];
  logic [ESLOT_W-1:0]  eslot_q, eslot_d;
  logic [ESUM_W-1:0]   esum_q, esum_d;
  logic                ering_we;

  // Interval history. Entries are only read once they have been written, so
  // the array carries no reset; the running sum replaces a sum over the ring.
  logic [IVAL_W-1:0]  iring_q [INTERVAL_DEPTH];
  logic [ISLOT_W-1:0] islot_q, islot_d;
  logic [ISUM_W-1:0]  isum_q, isum_d;
  logic               iring_we;
  logic [IVAL_W-1:0]  ival;

  logic [TIME_W-1:0]  last_q, last_d;
  logic [BEATS_W-1:0] beats_q, beats_d;
  logic [TEMPO_W-1:0] tempo_q, tempo_d;
  logic [CONF_W-1:0]  conf_q, conf_d;

  // Per-frame working registers.
  logic [ENERGY_W-1:0] energy_q, energy_d;
  logic [TIME_W-1:0]   now_q, now_d;
  logic [ENERGY_W-1:0] mean_q, mean_d, mean_now;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [TIME_W-1:0]   diff_q, diff_d;
  logic                later_q, later_d;
  logic                beat_q, beat_d;
  logic                beat_now;
  logic [BEATS_W-1:0]  cnt_q, cnt_d;

  // Shared divider registers.
  logic [DREM_W-1:0]  drem_q, drem_d;
  logic [DREM_W-1:0]  dden_q, dden_d;
  logic [TEMPO_W-1:0] dlow_q, dlow_d;
  logic [TEMPO_W-1:0] dq_q, dq_d;
  logic [TEMPO_W-1:0] dq_next;
  logic [DCNT_W-1:0]  dcnt_q, dcnt_d;
  logic               dtempo_q, dtempo_d;
  logic [DREM_W:0]    dsh;
  logic [DREM_W+1:0]  dtrial;
  logic               dge;

  // Operand preparation for the two divisions.
  logic [TNUM_W-1:0]   tnum;
  logic [ENERGY_W-1:0] dm;
  logic [SCALED_W-1:0] cnum;

  // Output register.
  logic               ovalid_q, ovalid_d;
  logic               obeat_q, obeat_d;
  logic [TEMPO_W-1:0] otempo_q, otempo_d;
  logic [CONF_W-1:0]  oconf_q, oconf_d;
  logic               out_free;
  logic               in_acc;

  assign in_i.ready          = (state_q == ST_IDLE);
  assign in_acc              = in_i.valid && (state_q == ST_IDLE);
  assign out_free            = !ovalid_q || out_o.ready;
  assign out_o.valid         = ovalid_q;
  assign out_o.beat          = obeat_q;
  assign out_o.tempo_q8      = otempo_q;
  assign out_o.confidence_q8 = oconf_q;

  // The mean is taken from the sum that already includes the current frame.
  assign mean_now = ENERGY_W'(esum_q / ENERGY_DEPTH);

  // Beat decision: energy above gain times mean, and the gap long enough.
  assign beat_now = later_q
                 && (PROD_W'({energy_q, {Q_FRAC{1'b0}}}) > prod_q)
                 && (diff_q > TIME_W'(min_gap_q));

  // Intervals that do not fit 32 bits are clamped.
  assign ival = (|diff_q[TIME_W-1:IVAL_W]) ? {IVAL_W{1'b1}} : diff_q[IVAL_W-1:0];

  assign tnum = TNUM_W'(TEMPO_NUM) * TNUM_W'(cnt_q);
  assign dm   = energy_q - mean_q;
  assign cnum = {dm, {Q_FRAC{1'b0}}};

  // The shared subtractor. In the check cycle it compares the upper part of
  // the numerator with the divisor: if that part is not smaller, the quotient
  // cannot fit and the result saturates. A zero divisor lands here too. In the
  // iteration cycles it performs one restoring step with the next numerator bit.
  assign dsh     = (state_q == ST_CHECK) ? {1'b0, drem_q} : {drem_q, dlow_q[TEMPO_W-1]};
  assign dtrial  = {1'b0, dsh} - {2'b0, dden_q};
  assign dge     = !dtrial[DREM_W+1];
  assign dq_next = {dq_q[TEMPO_W-2:0], dge};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_TEST;
        end
      end
      ST_TEST: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!beat_now) begin
          state_d = ST_OUT;
        end else if (beats_q != '0) begin
          state_d = ST_TLOAD;
        end else begin
          state_d = ST_CLOAD;
        end
      end
      ST_TLOAD: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (dge) begin
          state_d = dtempo_q ? ST_CLOAD : ST_OUT;
        end else begin
          state_d = ST_ITER;
        end
      end
      ST_ITER: begin
        if (dcnt_q == DCNT_W'(1)) begin
          state_d = dtempo_q ? ST_CLOAD : ST_OUT;
        end
      end
      ST_CLOAD: begin
        // A beat at or below the mean has zero confidence.
        state_d = (energy_q <= mean_q) ? ST_OUT : ST_CHECK;
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath control per state.
  always_comb begin
    eslot_d   = eslot_q;
    esum_d    = esum_q;
    ering_we  = 1'b0;
    islot_d   = islot_q;
    isum_d    = isum_q;
    iring_we  = 1'b0;
    last_d    = last_q;
    beats_d   = beats_q;
    tempo_d   = tempo_q;
    conf_d    = conf_q;
    energy_d  = energy_q;
    now_d     = now_q;
    mean_d    = mean_q;
    prod_d    = prod_q;
    diff_d    = diff_q;
    later_d   = later_q;
    beat_d    = beat_q;
    cnt_d     = cnt_q;
    drem_d    = drem_q;
    dden_d    = dden_q;
    dlow_d    = dlow_q;
    dq_d      = dq_q;
    dcnt_d    = dcnt_q;
    dtempo_d  = dtempo_q;
    obeat_d   = obeat_q;
    otempo_d  = otempo_q;
    oconf_d   = oconf_q;
    ovalid_d  = ovalid_q;

    if (ovalid_q && out_o.ready) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          energy_d = in_i.frame_energy;
          now_d    = in_i.time_us;
          ering_we = 1'b1;
          esum_d   = esum_q - ESUM_W'(ering_q[eslot_q]) + ESUM_W'(in_i.frame_energy);
          eslot_d  = (eslot_q == ESLOT_W'(ENERGY_DEPTH - 1)) ? '0 : eslot_q + 1'b1;
        end
      end
      ST_TEST: begin
        mean_d  = mean_now;
        prod_d  = PROD_W'(gain_q) * PROD_W'(mean_now);
        diff_d  = now_q - last_q;
        later_d = (now_q > last_q);
      end
      ST_DECIDE: begin
        beat_d = beat_now;
        if (beat_now) begin
          last_d = now_q;
          if (beats_q != BEATS_W'(INTERVAL_DEPTH + 1)) begin
            beats_d = beats_q + 1'b1;
          end
          // The first beat only marks the time; later ones add an interval.
          if (beats_q != '0) begin
            iring_we = 1'b1;
            islot_d  = (islot_q == ISLOT_W'(INTERVAL_DEPTH - 1)) ? '0 : islot_q + 1'b1;
            cnt_d    = (beats_q < BEATS_W'(INTERVAL_DEPTH)) ? beats_q
                                                            : BEATS_W'(INTERVAL_DEPTH);
            // Once the ring is full the entry being replaced leaves the sum.
            if (beats_q == BEATS_W'(INTERVAL_DEPTH + 1)) begin
              isum_d = isum_q + ISUM_W'(ival) - ISUM_W'(iring_q[islot_q]);
            end else begin
              isum_d = isum_q + ISUM_W'(ival);
            end
          end
        end
      end
      ST_TLOAD: begin
        drem_d   = DREM_W'(tnum[TNUM_W-1:TEMPO_W]);
        dlow_d   = tnum[TEMPO_W-1:0];
        dden_d   = isum_q;
        dcnt_d   = DCNT_W'(TEMPO_W);
        dtempo_d = 1'b1;
      end
      ST_CHECK: begin
        if (dge) begin
          if (dtempo_q) begin
            tempo_d = TEMPO_MAX;
          end else begin
            conf_d = CONF_MAX;
          end
        end
      end
      ST_ITER: begin
        drem_d = dge ? dtrial[DREM_W-1:0] : dsh[DREM_W-1:0];
        dlow_d = {dlow_q[TEMPO_W-2:0], 1'b0};
        dq_d   = dq_next;
        dcnt_d = dcnt_q - 1'b1;
        if (dcnt_q == DCNT_W'(1)) begin
          if (dtempo_q) begin
            tempo_d = dq_next;
          end else begin
            conf_d = dq_next[CONF_W-1:0];
          end
        end
      end
      ST_CLOAD: begin
        if (energy_q <= mean_q) begin
          conf_d = '0;
        end else begin
          drem_d   = DREM_W'(cnum[SCALED_W-1:CONF_W]);
          dlow_d   = {cnum[CONF_W-1:0], {(TEMPO_W - CONF_W){1'b0}}};
          dden_d   = DREM_W'(mean_q);
          dcnt_d   = DCNT_W'(CONF_W);
          dtempo_d = 1'b0;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          obeat_d  = beat_q;
          otempo_d = tempo_q;
          oconf_d  = conf_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      min_gap_q <= MIN_GAP_RESET;
      gain_q    <= GAIN_RESET;
      eslot_q   <= '0;
      esum_q    <= '0;
      for (int i = 0; i < ENERGY_DEPTH; i++) begin
        ering_q[i] <= '0;
      end
      islot_q   <= '0;
      isum_q    <= '0;
      last_q    <= '0;
      beats_q   <= '0;
      tempo_q   <= TEMPO_RESET;
      conf_q    <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      eslot_q  <= eslot_d;
      esum_q   <= esum_d;
      if (ering_we) begin
        ering_q[eslot_q] <= in_i.frame_energy;
      end
      islot_q  <= islot_d;
      isum_q   <= isum_d;
      last_q   <= last_d;
      beats_q  <= beats_d;
      tempo_q  <= tempo_d;
      conf_q   <= conf_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIN_GAP: min_gap_q <= cfg_data_i[GAP_W-1:0];
          CFG_GAIN:    gain_q    <= cfg_data_i[GAIN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Interval ring and working registers.
  always_ff @(posedge clk_i) begin
    if (iring_we) begin
      iring_q[islot_q] <= ival;
    end
    energy_q <= energy_d;
    now_q    <= now_d;
    mean_q   <= mean_d;
    prod_q   <= prod_d;
    diff_q   <= diff_d;
    later_q  <= later_d;
    beat_q   <= beat_d;
    cnt_q    <= cnt_d;
    drem_q   <= drem_d;
    dden_q   <= dden_d;
    dlow_q   <= dlow_d;
    dq_q     <= dq_d;
    dcnt_q   <= dcnt_d;
    dtempo_q <= dtempo_d;
    obeat_q  <= obeat_d;
    otempo_q <= otempo_d;
    oconf_q  <= oconf_d;
  end

endmodule

// ===== design/ebtd_checker.sv =====
`timescale 1ns / 1ps
`include "energy_beat_tempo_detector_unit_macros.svh"

module ebtd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic                          out_beat_i,
  input logic [ebtd_pkg::TEMPO_W-1:0]  out_tempo_i,
  input logic [ebtd_pkg::CONF_W-1:0]   out_conf_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // A frame keeps the block busy for at least the cycle after it is taken.
  `EBTD_ASSERT_NXT(a_busy_after_accept, in_acc, !in_ready_i, "input ready right after accept")

  // A new result appears only after the detector returned to idle.
  `EBTD_ASSERT_IMP(a_result_then_ready, $rose(out_valid_i), in_ready_i, "result without idle")

  // No result can appear while the frame just taken is still in the test or decide state.
  `EBTD_ASSERT_IMP(a_result_latency, $rose(out_valid_i),
                   !$past(in_acc) && !$past(in_acc, 2), "result too early after accept")

  // A stalled result holds its word.
  `EBTD_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i,
                   out_valid_i && $stable(out_beat_i) && $stable(out_tempo_i)
                   && $stable(out_conf_i), "stalled result changed")

endmodule

bind energy_beat_tempo_detector_unit ebtd_checker u_ebtd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_beat_i  (out_o.beat),
  .out_tempo_i (out_o.tempo_q8),
  .out_conf_i  (out_o.confidence_q8)
);
